[rtl/srs_pkg.sv]
// Shared types and constants of the systematic resampler.
`default_nettype none

package srs_pkg;

	localparam int unsigned PC_W        = 7;
	localparam logic [PC_W-1:0] PC_RESET = 7'd64;
	localparam int unsigned WEIGHT_IN_W = 32;
	localparam int unsigned OFF_W       = 16;
	localparam int unsigned IDX_W       = 6;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PREP,
		ST_RD,
		ST_MUL,
		ST_ACC,
		ST_CMP,
		ST_ERD,
		ST_EDEC
	} srs_state_t;

	typedef struct packed {
		logic init;
		logic mul;
		logic acc;
		logic step;
	} srs_arith_ctrl_t;

endpackage

`default_nettype wire

[rtl/srs_in_if.sv]
// Request channels of the systematic resampler: weight input and ancestor output.
`default_nettype none

interface srs_in_if import srs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [WEIGHT_IN_W-1:0] weight;
	logic [OFF_W-1:0]       offset;
	logic                   last;

	modport source (output valid, output weight, output offset, output last, input ready);
	modport sink   (input valid, input weight, input offset, input last, output ready);
endinterface

interface srs_out_if import srs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] slot;
	logic [IDX_W-1:0] ancestor;
	logic             degenerate;
	logic             final_res;

	modport source (output valid, output slot, output ancestor, output degenerate,
		output final_res, input ready);
	modport sink   (input valid, input slot, input ancestor, input degenerate,
		input final_res, output ready);
endinterface

`default_nettype wire

[rtl/srs_arith.sv]
// Stratum compare unit: running scaled prefix sum against the stratum threshold.
`default_nettype none

module srs_arith import srs_pkg::*; #(
	parameter int unsigned WB = 32,
	parameter int unsigned AW = 6
) (
	input  logic                 clk,
	input  srs_arith_ctrl_t      ctrl,
	input  logic [WB-1:0]        w,
	input  logic [AW:0]          n,
	input  logic [OFF_W-1:0]     off,
	input  logic [WB+AW-1:0]     sum,
	output logic                 beyond
);

	localparam int unsigned SUM_W  = WB + AW;
	localparam int unsigned PROD_W = WB + AW + 1;
	localparam int unsigned BASE_W = OFF_W + SUM_W;
	localparam int unsigned ACC_W  = SUM_W + AW + 1 + OFF_W;

	logic [PROD_W-1:0] prod_q;
	logic [BASE_W-1:0] base;
	logic [ACC_W-1:0]  lhs_q;
	logic [ACC_W-1:0]  rhs_q;

	// lhs holds C_k * N * 2^16, rhs holds (j * 2^16 + offset) * S.
	assign base   = BASE_W'(off) * BASE_W'(sum);
	assign beyond = lhs_q > rhs_q;

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_q <= PROD_W'(w) * PROD_W'(n);
		end
		if (ctrl.init) begin
			lhs_q <= '0;
			rhs_q <= ACC_W'(base);
		end else begin
			if (ctrl.acc) begin
				lhs_q <= lhs_q + ACC_W'({prod_q, {OFF_W{1'b0}}});
			end
			if (ctrl.step) begin
				rhs_q <= rhs_q + ACC_W'({sum, {OFF_W{1'b0}}});
			end
		end
	end

endmodule

`default_nettype wire

[rtl/systematic_resampler.sv]
// Systematic resampler top level: weight store, stratum sequencer and ancestor map output.
// Usage:
// Weights arrive on the particle channel, one request per cycle while ready is high.
// The request with last set carries the stratum offset and starts resampling.
// Weights beyond the configured particle count are dropped; missing ones count as zero.
// After last, the block emits one request per slot on the resample channel,
// slot 0 to N-1, with the ancestor index; final_res marks slot N-1.
// Resampling runs a setup step, then the count pass (memory read, multiply,
// accumulate and a closing compare per particle, one compare per stratum)
// and then the output pass (memory read, decide per slot). Particle ready
// is low during both passes.
// If all weights are zero the count pass is skipped and the identity map is
// emitted with degenerate set.
// A stalled receiver holds the output register and pauses the output pass;
// the next set of weights is accepted while the last result still waits.
// Reset sets the particle count to 64 and empties the load position and sum;
// the memories need no clearing. A write of cfg_wdata aborts any load in progress.
`default_nettype none

module systematic_resampler import srs_pkg::*; #(
	parameter int unsigned MAX_PARTICLES = 64,
	parameter int unsigned WEIGHT_BITS   = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [PC_W-1:0] cfg_wdata,
	srs_in_if.sink          particle,
	srs_out_if.source       resample
);

	localparam int unsigned AW     = $clog2(MAX_PARTICLES);
	localparam int unsigned CW     = AW + 1;
	localparam int unsigned WB     = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
	localparam int unsigned SUM_W  = WB + AW;
	localparam int unsigned WORD_W = CW + WB;

	srs_state_t      state_q, state_d;
	srs_arith_ctrl_t actl;

	logic [PC_W-1:0]   pc_q;
	logic [CW-1:0]     n_eff;
	logic [CW-1:0]     load_pos_q;
	logic [SUM_W-1:0]  sum_q;
	logic [OFF_W-1:0]  off_q;
	logic              degen_q;
	logic [AW-1:0]     k_q;
	logic [AW-1:0]     s_q;
	logic [AW-1:0]     e_q;
	logic [CW-1:0]     j_q;
	logic [CW-1:0]     cnt_q;

	logic [WORD_W-1:0] part_mem [MAX_PARTICLES];
	logic [AW-1:0]     anc_mem  [MAX_PARTICLES];
	logic [WORD_W-1:0] part_rd_q;
	logic [AW-1:0]     anc_rd_q;

	logic              ov_q;
	logic [IDX_W-1:0]  slot_q;
	logic [IDX_W-1:0]  anc_q;
	logic              deg_q;
	logic              fin_q;

	logic              accept;
	logic              load_wr;
	logic              take;
	logic              wb_wr;
	logic              out_load;
	logic              beyond;
	logic              k_last;
	logic              s_last;
	logic              surv;
	logic [WB-1:0]     w_in;
	logic [WB-1:0]     w_sel;
	logic [AW-1:0]     part_raddr;

	always_comb begin
		if (pc_q == '0) begin
			n_eff = CW'(1);
		end else if (pc_q > PC_W'(MAX_PARTICLES)) begin
			n_eff = CW'(MAX_PARTICLES);
		end else begin
			n_eff = CW'(pc_q);
		end
	end

	assign particle.ready = (state_q == ST_LOAD);
	assign accept         = particle.valid && particle.ready;
	assign load_wr        = accept && (load_pos_q < n_eff);
	assign w_in           = particle.weight[WB-1:0];

	assign k_last = (CW'(k_q) + CW'(1)) == n_eff;
	assign s_last = (CW'(s_q) + CW'(1)) == n_eff;
	assign surv   = part_rd_q[WORD_W-1 -: CW] != '0;
	// Slots past the loaded ones weigh zero.
	assign w_sel  = (CW'(k_q) < load_pos_q) ? part_rd_q[WB-1:0] : '0;

	assign part_raddr = (state_q == ST_ERD || state_q == ST_EDEC) ? s_q : k_q;

	srs_arith #(
		.WB (WB),
		.AW (AW)
	) u_arith (
		.clk    (clk),
		.ctrl   (actl),
		.w      (w_sel),
		.n      (n_eff),
		.off    (off_q),
		.sum    (sum_q),
		.beyond (beyond)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		actl     = '0;
		take     = 1'b0;
		wb_wr    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && particle.last) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				actl.init = 1'b1;
				state_d   = (sum_q == '0) ? ST_ERD : ST_RD;
			end
			ST_RD: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				actl.mul = 1'b1;
				state_d  = ST_ACC;
			end
			ST_ACC: begin
				actl.acc = 1'b1;
				state_d  = ST_CMP;
			end
			ST_CMP: begin
				if (beyond && (j_q < n_eff)) begin
					take      = 1'b1;
					actl.step = 1'b1;
				end else begin
					wb_wr   = 1'b1;
					state_d = k_last ? ST_ERD : ST_RD;
				end
			end
			ST_ERD: begin
				state_d = ST_EDEC;
			end
			ST_EDEC: begin
				if (!ov_q || resample.ready) begin
					out_load = 1'b1;
					state_d  = s_last ? ST_LOAD : ST_ERD;
				end
			end
		endcase
	end

	// Weight and child count share one word; the count pass writes the count back.
	always_ff @(posedge clk) begin
		if (load_wr) begin
			part_mem[load_pos_q[AW-1:0]] <= {CW'(0), w_in};
		end else if (wb_wr) begin
			part_mem[k_q] <= {cnt_q, part_rd_q[WB-1:0]};
		end
		part_rd_q <= part_mem[part_raddr];
	end

	// Extra copies are queued in stratum order; empty slots take them in turn.
	always_ff @(posedge clk) begin
		if (take && (cnt_q != '0)) begin
			anc_mem[e_q] <= k_q;
		end
		anc_rd_q <= anc_mem[e_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= PC_RESET;
			load_pos_q <= '0;
			sum_q      <= '0;
			off_q      <= '0;
			degen_q    <= 1'b0;
			k_q        <= '0;
			s_q        <= '0;
			e_q        <= '0;
			j_q        <= '0;
			cnt_q      <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				pc_q       <= cfg_wdata;
				load_pos_q <= '0;
				sum_q      <= '0;
			end else if (load_wr) begin
				load_pos_q <= load_pos_q + CW'(1);
				sum_q      <= sum_q + SUM_W'(w_in);
			end else if (out_load && s_last) begin
				load_pos_q <= '0;
				sum_q      <= '0;
			end

			// The offset rides on the request that closes the set.
			if (accept && particle.last) begin
				off_q <= particle.offset;
			end

			if (state_q == ST_PREP) begin
				degen_q <= (sum_q == '0);
				k_q     <= '0;
				s_q     <= '0;
				e_q     <= '0;
				j_q     <= '0;
			end
			if (state_q == ST_ACC) begin
				cnt_q <= '0;
			end
			if (take) begin
				cnt_q <= cnt_q + CW'(1);
				j_q   <= j_q + CW'(1);
				if (cnt_q != '0) begin
					e_q <= e_q + AW'(1);
				end
			end
			if (wb_wr) begin
				if (k_last) begin
					e_q <= '0;
					s_q <= '0;
				end else begin
					k_q <= k_q + AW'(1);
				end
			end
			if (out_load) begin
				if (!s_last) begin
					s_q <= s_q + AW'(1);
				end
				if (!degen_q && !surv) begin
					e_q <= e_q + AW'(1);
				end
			end

			if (out_load) begin
				ov_q <= 1'b1;
			end else if (resample.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			slot_q <= IDX_W'(s_q);
			anc_q  <= (degen_q || surv) ? IDX_W'(s_q) : IDX_W'(anc_rd_q);
			deg_q  <= degen_q;
			fin_q  <= s_last;
		end
	end

	assign resample.valid      = ov_q;
	assign resample.slot       = slot_q;
	assign resample.ancestor   = anc_q;
	assign resample.degenerate = deg_q;
	assign resample.final_res  = fin_q;

endmodule

`default_nettype wire

[rtl/srs_chk.sv]
// Port-level checker for the systematic resampler and its bind to the top level.
`default_nettype none

module srs_chk import srs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [IDX_W-1:0] slot,
	input logic [IDX_W-1:0] ancestor,
	input logic             degenerate,
	input logic             final_res
);

	logic             out_acc;
	logic [IDX_W-1:0] exp_slot_q;
	logic             mid_q;
	logic             deg_q;

	assign out_acc = out_valid && out_ready;

	// Tracks the slot order and the pass flag seen so far.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_slot_q <= '0;
			mid_q      <= 1'b0;
			deg_q      <= 1'b0;
		end else if (out_acc) begin
			exp_slot_q <= final_res ? '0 : slot + IDX_W'(1);
			mid_q      <= !final_res;
			deg_q      <= degenerate;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(ancestor)
			&& $stable(final_res))
		else $error("result changed while stalled");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && degenerate |-> ancestor == slot)
		else $error("degenerate pass without identity map");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> slot == exp_slot_q)
		else $error("slot out of order");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && mid_q |-> degenerate == deg_q)
		else $error("degenerate flag changed within a pass");

endmodule

bind systematic_resampler srs_chk u_srs_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (resample.valid),
	.out_ready  (resample.ready),
	.slot       (resample.slot),
	.ancestor   (resample.ancestor),
	.degenerate (resample.degenerate),
	.final_res  (resample.final_res)
);

`default_nettype wire
